// File: hdl/assert_macros.svh
// Assertion helpers for the queue checkers.
// Each macro samples on clk and stays quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/afp_pkg.sv
package afp_pkg;

    localparam int OCC_W = 5;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    localparam logic KIND_NORMAL = 1'b0;
    localparam logic KIND_ALARM  = 1'b1;

    typedef enum logic [2:0] {
        ST_SENT      = 3'd0,
        ST_NO_ROOM   = 3'd1,
        ST_ALARM_RX  = 3'd2,
        ST_NORMAL_RX = 3'd3,
        ST_NO_MSG    = 3'd4
    } status_t;

    // Everything of a result except the data word.
    typedef struct packed {
        status_t            status;
        logic [OCC_W-1:0]   occupancy;
        logic               alarm_held;
    } res_info_t;

endpackage

// File: hdl/afp_mem.sv
module afp_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] ram_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/afp_ctrl.sv
module afp_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic                     op,
    input  logic                     kind,
    input  logic [DATA_WIDTH-1:0]    payload,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [DATA_WIDTH-1:0]    mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    output afp_pkg::res_info_t       res,
    output logic [DATA_WIDTH-1:0]    res_data,
    output logic                     res_now,
    output logic                     res_mem
);

    import afp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  alarm_valid_reg, alarm_valid_next;
    logic [DATA_WIDTH-1:0] alarm_word_reg, alarm_word_next;
    status_t               status;
    logic [CW:0]           occ_sum;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        count_next       = count_reg;
        alarm_valid_next = alarm_valid_reg;
        alarm_word_next  = alarm_word_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        res_mem          = 1'b0;
        res_data         = '0;
        status           = ST_NO_MSG;
        if (fire)
        begin
            if (op == OP_SEND)
            begin
                if (kind == KIND_ALARM)
                begin
                    if (alarm_valid_reg)
                    begin
                        status = ST_NO_ROOM;
                    end
                    else
                    begin
                        alarm_word_next  = payload;
                        alarm_valid_next = 1'b1;
                        status           = ST_SENT;
                    end
                end
                else if (count_reg == CW'(DEPTH))
                begin
                    status = ST_NO_ROOM;
                end
                else
                begin
                    mem_we      = 1'b1;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                    count_next  = count_reg + 1'b1;
                    status      = ST_SENT;
                end
            end
            else
            begin
                if (alarm_valid_reg)
                begin
                    res_data         = alarm_word_reg;
                    alarm_valid_next = 1'b0;
                    status           = ST_ALARM_RX;
                end
                else if (count_reg != '0)
                begin
                    // word arrives from the RAM in the next cycle
                    mem_re      = 1'b1;
                    res_mem     = 1'b1;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    count_next  = count_reg - 1'b1;
                    status      = ST_NORMAL_RX;
                end
                else
                begin
                    status = ST_NO_MSG;
                end
            end
        end
    end

    assign occ_sum        = {1'b0, count_next} + {{CW{1'b0}}, alarm_valid_next};
    assign res.status     = status;
    assign res.occupancy  = OCC_W'(occ_sum);
    assign res.alarm_held = alarm_valid_next;
    assign res_now        = fire && !res_mem;

    assign mem_waddr = wr_ptr_reg;
    assign mem_wdata = payload;
    assign mem_raddr = rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            count_reg       <= '0;
            alarm_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            count_reg       <= count_next;
            alarm_valid_reg <= alarm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alarm_word_reg <= alarm_word_next;
    end

endmodule

// File: hdl/alarm_priority_fifo.sv
// Message queue: a ring-buffer FIFO of DEPTH normal words in a synchronous RAM plus a
// single alarm slot in flops. Every accepted word (op 0 send, op 1 receive) gives one
// result: status, received word, occupancy after the step and the alarm flag. A receive
// takes the alarm first, then the oldest normal word. Sends, alarm receives and empty
// receives load their result straight into the output stage; a receive from the RAM
// comes via the RAM read register, and in_ready is low while that read is in flight.
// A registered output stage takes the next word in the same cycle its result is taken,
// so a stream of sends runs at one word per cycle while out_ready stays high; a stalled
// result holds in_ready low until it is taken. Occupancy is reported in 5 bits.
module alarm_priority_fifo #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic                  kind,
    input  logic [DATA_WIDTH-1:0] payload,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [afp_pkg::OCC_W-1:0] occupancy,
    output logic                  alarm_held
);

    import afp_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic                  fire;
    logic                  mem_we, mem_re;
    logic [PW-1:0]         mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
    res_info_t             res;
    logic [DATA_WIDTH-1:0] res_data;
    logic                  res_now, res_mem;

    logic                  pend_reg, pend_next;
    res_info_t             pend_info_reg, pend_info_next;
    logic                  out_valid_reg, out_valid_next;
    res_info_t             out_info_reg, out_info_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;

    assign in_ready = !pend_reg && (!out_valid_reg || out_ready);
    assign fire     = in_valid && in_ready;

    afp_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .op        (op),
        .kind      (kind),
        .payload   (payload),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .res       (res),
        .res_data  (res_data),
        .res_now   (res_now),
        .res_mem   (res_mem)
    );

    afp_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output stage is always free by the time a pending RAM read returns
    always_comb
    begin
        pend_next      = res_mem;
        pend_info_next = res_mem ? res : pend_info_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_info_next  = out_info_reg;
        out_data_next  = out_data_reg;
        if (res_now)
        begin
            out_valid_next = 1'b1;
            out_info_next  = res;
            out_data_next  = res_data;
        end
        else if (pend_reg)
        begin
            out_valid_next = 1'b1;
            out_info_next  = pend_info_reg;
            out_data_next  = mem_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_info_reg <= pend_info_next;
        out_info_reg  <= out_info_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_info_reg.status;
    assign data_out   = out_data_reg;
    assign occupancy  = out_info_reg.occupancy;
    assign alarm_held = out_info_reg.alarm_held;

endmodule

// File: hdl/afp_checker.sv
`include "assert_macros.svh"

module afp_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [2:0]            status,
    input logic [DATA_WIDTH-1:0] data_out,
    input logic [afp_pkg::OCC_W-1:0] occupancy,
    input logic                  alarm_held
);

    import afp_pkg::*;

    `AFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
                     "result dropped before taken")

    `AFP_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready,
                    "input taken while output stalled")

    `AFP_ASSERT_NOW(a_zero_data,
                    out_valid && (status == ST_SENT || status == ST_NO_ROOM ||
                                  status == ST_NO_MSG),
                    data_out == '0, "nonzero word without receive")

    `AFP_ASSERT_NOW(a_empty_rx, out_valid && status == ST_NO_MSG,
                    occupancy == '0 && !alarm_held, "no message while queue holds words")

    `AFP_ASSERT_NOW(a_alarm_taken, out_valid && status == ST_ALARM_RX, !alarm_held,
                    "alarm still held after receive")

endmodule

bind alarm_priority_fifo afp_checker #(.DATA_WIDTH(DATA_WIDTH)) u_afp_checker (.*);
